>>> hw/rtl/slt_pkg.sv
// shared types, constants and byte tables for the serial-to-lcd line terminal
// no dependencies; imported by slt_ctrl, slt_datapath and the top level
package slt_pkg;

	// characters on row one before it is cleared ahead of the next character
	localparam int ROW_WIDTH = 16;

	localparam int FILL_W      = $clog2(ROW_WIDTH + 1);
	localparam int CLEAR_LAST  = ROW_WIDTH + 1;
	localparam int ROW2_LAST   = 14;
	localparam int REPORT_LAST = 2;
	localparam int IDX_MAX     = (CLEAR_LAST > ROW2_LAST) ? CLEAR_LAST : ROW2_LAST;
	localparam int IDX_W       = $clog2(IDX_MAX + 1);

	localparam logic [1:0] CMD_RX     = 2'd0;
	localparam logic [1:0] CMD_REPORT = 2'd1;
	localparam logic [1:0] CMD_RESET  = 2'd2;

	localparam logic       DEST_LCD  = 1'b0;
	localparam logic       DEST_UART = 1'b1;

	localparam logic [7:0] LCD_ROW1  = 8'h80;
	localparam logic [7:0] LCD_ROW2  = 8'hC0;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	typedef enum logic [4:0] {
		SEG_CLEAR  = 5'b00001,
		SEG_CHAR   = 5'b00010,
		SEG_ROW2   = 5'b00100,
		SEG_CURSOR = 5'b01000,
		SEG_REPORT = 5'b10000
	} seg_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic zero_counts;
		logic clr_fill;
		logic bump;
		logic last;
		seg_t seg;
	} ctrl_cmd_t;

	typedef struct packed {
		logic adv;
		logic seg_done;
		logic new_nl;
		logic fill_full;
		logic item_nl;
		logic item_reset;
	} dp_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		digit_char = CH_ZERO + {4'h0, d};
	endfunction

	// row two: set-address command, label, then the three count digits
	function automatic logic [7:0] row2_byte(input logic [3:0] pos, input logic [3:0] h,
			input logic [3:0] t, input logic [3:0] o);
		unique case (pos)
			4'd0:    row2_byte = LCD_ROW2;
			4'd1:    row2_byte = 8'h43; // C
			4'd2:    row2_byte = 8'h68; // h
			4'd3:    row2_byte = 8'h61; // a
			4'd4:    row2_byte = 8'h72; // r
			4'd5:    row2_byte = CH_SPACE;
			4'd6:    row2_byte = 8'h52; // R
			4'd7:    row2_byte = 8'h65; // e
			4'd8:    row2_byte = 8'h63; // c
			4'd9:    row2_byte = 8'h76; // v
			4'd10:   row2_byte = 8'h3A; // :
			4'd11:   row2_byte = CH_SPACE;
			4'd12:   row2_byte = digit_char(h);
			4'd13:   row2_byte = digit_char(t);
			4'd14:   row2_byte = digit_char(o);
			default: row2_byte = CH_SPACE;
		endcase
	endfunction

endpackage

>>> hw/rtl/slt_ctrl.sv
// sequencer: walks the byte segments an item calls for, one byte per step
// depends on slt_pkg; drives slt_datapath through ctrl_cmd_t
module slt_ctrl import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] cmd,
	output logic       in_stall,
	input  dp_stat_t   stat_i,
	output ctrl_cmd_t  cmd_o
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_CLEAR  = 6'b000010,
		ST_CHAR   = 6'b000100,
		ST_ROW2   = 6'b001000,
		ST_CURSOR = 6'b010000,
		ST_REPORT = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd_o = '0;
		cmd_o.seg = SEG_CLEAR;
		unique case (state_q)
			ST_IDLE: begin
				cmd_o.load = in_valid;
				if (in_valid) begin
					unique case (cmd)
						CMD_RX: begin
							state_d = (stat_i.new_nl || stat_i.fill_full) ? ST_CLEAR : ST_CHAR;
						end
						CMD_REPORT: begin
							state_d = ST_REPORT;
						end
						CMD_RESET: begin
							cmd_o.zero_counts = 1'b1;
							state_d = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				cmd_o.seg = SEG_CLEAR;
				if (stat_i.adv) begin
					cmd_o.emit = 1'b1;
					if (stat_i.seg_done) begin
						cmd_o.clr_fill = 1'b1;
						cmd_o.last = stat_i.item_nl;
						priority if (stat_i.item_nl) begin
							state_d = ST_IDLE;
						end else if (stat_i.item_reset) begin
							state_d = ST_ROW2;
						end else begin
							state_d = ST_CHAR;
						end
					end
				end
			end
			ST_CHAR: begin
				cmd_o.seg = SEG_CHAR;
				if (stat_i.adv) begin
					cmd_o.emit = 1'b1;
					cmd_o.bump = 1'b1;
					state_d = ST_ROW2;
				end
			end
			ST_ROW2: begin
				cmd_o.seg = SEG_ROW2;
				if (stat_i.adv) begin
					cmd_o.emit = 1'b1;
					if (stat_i.seg_done) begin
						state_d = ST_CURSOR;
					end
				end
			end
			ST_CURSOR: begin
				cmd_o.seg = SEG_CURSOR;
				if (stat_i.adv) begin
					cmd_o.emit = 1'b1;
					cmd_o.last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_REPORT: begin
				cmd_o.seg = SEG_REPORT;
				if (stat_i.adv) begin
					cmd_o.emit = 1'b1;
					cmd_o.last = stat_i.seg_done;
					if (stat_i.seg_done) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_last_needs_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_o.last |-> cmd_o.emit)
		else $error("last flag raised without a byte");

	a_cursor_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CURSOR) && cmd_o.emit |=> (state_q == ST_IDLE))
		else $error("cursor byte did not end the item");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !cmd_o.emit)
		else $error("byte issued while idle");

endmodule

>>> hw/rtl/slt_datapath.sv
// datapath: item register, bcd count, row fill, segment index, byte select
// and the output register; depends on slt_pkg, driven by slt_ctrl
module slt_datapath import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	input  ctrl_cmd_t  cmd_i,
	output dp_stat_t   stat_o,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       dest,
	output logic [7:0] data_byte,
	output logic       last
);

	logic [7:0]        rx_q;
	logic              nl_q;
	logic              reset_item_q;
	logic [3:0]        hund_q, tens_q, ones_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  report_start;
	logic              seg_done;
	logic              new_nl;
	logic [7:0]        byte_d;
	logic              dest_d;
	logic              out_valid_q;
	logic              dest_q;
	logic [7:0]        byte_q;
	logic              last_q;

	assign new_nl = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	// leading zeros are skipped by starting the digit walk further in
	always_comb begin
		priority if (hund_q != 4'd0) begin
			report_start = '0;
		end else if (tens_q != 4'd0) begin
			report_start = IDX_W'(1);
		end else begin
			report_start = IDX_W'(REPORT_LAST);
		end
	end

	always_comb begin
		unique case (cmd_i.seg)
			SEG_CLEAR:  seg_done = (idx_q == IDX_W'(CLEAR_LAST));
			SEG_ROW2:   seg_done = (idx_q == IDX_W'(ROW2_LAST));
			SEG_REPORT: seg_done = (idx_q == IDX_W'(REPORT_LAST));
			default:    seg_done = 1'b1;
		endcase
	end

	always_comb begin
		dest_d = DEST_LCD;
		unique case (cmd_i.seg)
			SEG_CLEAR: begin
				byte_d = ((idx_q == '0) || (idx_q == IDX_W'(CLEAR_LAST))) ? LCD_ROW1 : CH_SPACE;
			end
			SEG_CHAR: begin
				byte_d = rx_q;
			end
			SEG_ROW2: begin
				byte_d = row2_byte(idx_q[3:0], hund_q, tens_q, ones_q);
			end
			SEG_CURSOR: begin
				byte_d = LCD_ROW1 + 8'(fill_q);
			end
			SEG_REPORT: begin
				dest_d = DEST_UART;
				unique case (idx_q)
					IDX_W'(0): byte_d = digit_char(hund_q);
					IDX_W'(1): byte_d = digit_char(tens_q);
					default:   byte_d = digit_char(ones_q);
				endcase
			end
			default: begin
				byte_d = CH_SPACE;
			end
		endcase
	end

	assign stat_o.adv        = !out_valid_q || !out_stall;
	assign stat_o.seg_done   = seg_done;
	assign stat_o.new_nl     = new_nl;
	assign stat_o.fill_full  = (fill_q >= FILL_W'(ROW_WIDTH));
	assign stat_o.item_nl    = nl_q;
	assign stat_o.item_reset = reset_item_q;

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			rx_q <= rx_byte;
			nl_q <= (cmd == CMD_RX) && new_nl;
			reset_item_q <= (cmd == CMD_RESET);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hund_q <= 4'd0;
			tens_q <= 4'd0;
			ones_q <= 4'd0;
			fill_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd_i.zero_counts) begin
				hund_q <= 4'd0;
				tens_q <= 4'd0;
				ones_q <= 4'd0;
				fill_q <= '0;
			end else if (cmd_i.clr_fill) begin
				fill_q <= '0;
			end else if (cmd_i.bump) begin
				fill_q <= fill_q + FILL_W'(1);
				// bcd increment, 999 rolls over to 000
				if (ones_q == 4'd9) begin
					ones_q <= 4'd0;
					if (tens_q == 4'd9) begin
						tens_q <= 4'd0;
						hund_q <= (hund_q == 4'd9) ? 4'd0 : hund_q + 4'd1;
					end else begin
						tens_q <= tens_q + 4'd1;
					end
				end else begin
					ones_q <= ones_q + 4'd1;
				end
			end
			if (cmd_i.load) begin
				idx_q <= (cmd == CMD_REPORT) ? report_start : '0;
			end else if (cmd_i.emit) begin
				idx_q <= seg_done ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd_i.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			dest_q <= dest_d;
			byte_q <= byte_d;
			last_q <= cmd_i.last;
		end
	end

	assign out_valid = out_valid_q;
	assign dest      = dest_q;
	assign data_byte = byte_q;
	assign last      = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ROW_WIDTH))
		else $error("row fill beyond row width");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(hund_q <= 4'd9) && (tens_q <= 4'd9) && (ones_q <= 4'd9))
		else $error("count digit out of decimal range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !cmd_i.emit)
		else $error("waiting byte overwritten");

	a_idx_home: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.load |-> (idx_q == '0))
		else $error("segment index not home at item start");

endmodule

>>> hw/rtl/serial_to_lcd_line_terminal_core.sv
// serial-to-lcd line terminal: one item at a time, one output byte per cycle
// while the output is not stalled; loading an item leaves idle and each byte
// is registered in the output register; the input stalls until the last byte
// is issued, and longer under output stall; an unused command gives nothing
// reset: counts and row fill clear to zero, sequencer idle, output empty
// depends on slt_pkg, slt_ctrl and slt_datapath
module serial_to_lcd_line_terminal_core import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       dest,
	output logic [7:0] data_byte,
	output logic       last
);

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	slt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_stall (in_stall),
		.stat_i   (dp_stat),
		.cmd_o    (ctrl_cmd)
	);

	slt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rx_byte   (rx_byte),
		.cmd_i     (ctrl_cmd),
		.stat_o    (dp_stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dest      (dest),
		.data_byte (data_byte),
		.last      (last)
	);

endmodule
